// ===== rtl/core/fgcd_pkg.sv =====
// Shared types and constants for the framed gain command decoder.
// No dependencies; imported by every module of the block.
package fgcd_pkg;

    localparam int HEAD_LEN = 6;
    localparam int GAIN_COUNT = 6;
    localparam logic [7:0] BUFFER_BYTES = 8'd128;
    localparam logic [7:0] COUNT_MAX = 8'hff;

    localparam logic [7:0] START_RESET = 8'hff;
    localparam logic [7:0] END_RESET = 8'hfe;

    localparam logic [7:0] CODE_LEFT = 8'h10;
    localparam logic [7:0] CODE_RIGHT = 8'h20;
    localparam logic [7:0] CODE_RELOAD = 8'h30;
    localparam logic [7:0] SUB_KP = 8'h01;
    localparam logic [7:0] SUB_KI = 8'h02;
    localparam logic [7:0] SUB_KD = 8'h03;

    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_END = 2'd1;

    localparam logic [1:0] ACT_NOOP = 2'd0;
    localparam logic [1:0] ACT_SET = 2'd1;
    localparam logic [1:0] ACT_RELOAD = 2'd2;

    localparam logic [1:0] GIDX_KP = 2'd0;
    localparam logic [1:0] GIDX_KI = 2'd1;
    localparam logic [1:0] GIDX_KD = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic        motor;
        logic [1:0]  gain_index;
        logic [31:0] gain_bits;
        logic        overlong;
    } cmd_t;

endpackage

// ===== rtl/core/fgcd_front.sv =====
// Front end: frame tracking, head byte capture and command classification.
// Depends on fgcd_pkg.
module fgcd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_fire,
    input  logic [7:0]        rx_byte,
    input  logic              cfg_fire,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    output logic              cmd_push,
    output fgcd_pkg::cmd_t    cmd
);
    import fgcd_pkg::*;

    logic [7:0] start_reg;
    logic [7:0] end_reg;
    logic       in_frame_reg;
    logic [7:0] count_reg;
    logic       over_reg;
    logic [7:0] head_reg [HEAD_LEN];

    logic is_end;
    logic sub_ok;

    assign is_end = in_frame_reg && (rx_byte == end_reg);
    assign cmd_push = byte_fire && is_end;
    assign sub_ok = (head_reg[1] == SUB_KP) || (head_reg[1] == SUB_KI)
                 || (head_reg[1] == SUB_KD);

    always_comb
    begin
        cmd.action = ACT_NOOP;
        cmd.motor = 1'b0;
        cmd.gain_index = GIDX_KP;
        cmd.gain_bits = '0;
        cmd.overlong = over_reg;
        priority if (((head_reg[0] == CODE_LEFT) || (head_reg[0] == CODE_RIGHT)) && sub_ok)
        begin
            cmd.action = ACT_SET;
            cmd.motor = (head_reg[0] == CODE_RIGHT);
            cmd.gain_index = head_reg[1][1:0] - 2'd1;
            cmd.gain_bits = {head_reg[5], head_reg[4], head_reg[3], head_reg[2]};
        end
        else if (head_reg[0] == CODE_RELOAD)
        begin
            cmd.action = ACT_RELOAD;
        end
        else
        begin
            cmd.action = ACT_NOOP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_RESET;
            end_reg <= END_RESET;
        end
        else if (cfg_fire)
        begin
            if (cfg_index == CFG_START)
                start_reg <= cfg_data;
            else if (cfg_index == CFG_END)
                end_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            count_reg <= '0;
            over_reg <= 1'b0;
            for (int i = 0; i < HEAD_LEN; i++)
                head_reg[i] <= '0;
        end
        else if (byte_fire)
        begin
            priority if (!in_frame_reg)
            begin
                if (rx_byte == start_reg)
                begin
                    in_frame_reg <= 1'b1;
                    count_reg <= '0;
                    over_reg <= 1'b0;
                end
            end
            else if (is_end)
            begin
                in_frame_reg <= 1'b0;
            end
            else
            begin
                if (count_reg >= BUFFER_BYTES)
                    over_reg <= 1'b1;
                if (count_reg < 8'(HEAD_LEN))
                    head_reg[count_reg[2:0]] <= rx_byte;
                if (count_reg != COUNT_MAX)
                    count_reg <= count_reg + 8'd1;
            end
        end
    end

endmodule

// ===== rtl/core/fgcd_cmd_queue.sv =====
// Two-entry command queue between the front end and the result engine.
// Depends on fgcd_pkg.
module fgcd_cmd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fgcd_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output logic              full,
    output logic              q_valid,
    output fgcd_pkg::cmd_t    q_cmd
);
    import fgcd_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full = (fill_reg == 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_cmd = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            unique case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 2'd1;
                2'b01:   fill_reg <= fill_reg - 2'd1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

// ===== rtl/core/fgcd_back.sv =====
// Result engine: gain store updates and result sequencing into the output register.
// Depends on fgcd_pkg.
module fgcd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  fgcd_pkg::cmd_t    q_cmd,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output fgcd_pkg::cmd_t    out_cmd,
    output logic              out_last
);
    import fgcd_pkg::*;

    logic [31:0] gain_reg [GAIN_COUNT];
    logic [1:0]  rl_cnt_reg;
    logic        rl_over_reg;
    logic        out_valid_reg;
    cmd_t        out_cmd_reg;
    logic        out_last_reg;

    logic       out_free;
    logic [2:0] set_idx;

    assign out_free = !out_valid_reg || out_ready;
    assign pop = q_valid && out_free && (rl_cnt_reg == 2'd0);
    assign set_idx = q_cmd.motor ? ({1'b0, q_cmd.gain_index} + 3'd3)
                                 : {1'b0, q_cmd.gain_index};

    assign out_valid = out_valid_reg;
    assign out_cmd = out_cmd_reg;
    assign out_last = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GAIN_COUNT; i++)
                gain_reg[i] <= '0;
        end
        else if (pop && (q_cmd.action == ACT_SET))
        begin
            gain_reg[set_idx] <= q_cmd.gain_bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rl_cnt_reg <= '0;
            rl_over_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (rl_cnt_reg != 2'd0)
            begin
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                    rl_cnt_reg <= (rl_cnt_reg == GIDX_KD) ? 2'd0 : rl_cnt_reg + 2'd1;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b1;
                if (q_cmd.action == ACT_RELOAD)
                begin
                    rl_cnt_reg <= GIDX_KI;
                    rl_over_reg <= q_cmd.overlong;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if ((rl_cnt_reg != 2'd0) && out_free)
        begin
            out_cmd_reg.action <= ACT_RELOAD;
            out_cmd_reg.motor <= 1'b0;
            out_cmd_reg.gain_index <= rl_cnt_reg;
            out_cmd_reg.gain_bits <= gain_reg[{1'b0, rl_cnt_reg}];
            out_cmd_reg.overlong <= rl_over_reg;
            out_last_reg <= (rl_cnt_reg == GIDX_KD);
        end
        else if ((rl_cnt_reg == 2'd0) && pop)
        begin
            out_cmd_reg.action <= q_cmd.action;
            out_cmd_reg.motor <= q_cmd.motor;
            out_cmd_reg.gain_index <= q_cmd.gain_index;
            out_cmd_reg.gain_bits <= (q_cmd.action == ACT_RELOAD) ? gain_reg[0]
                                                                  : q_cmd.gain_bits;
            out_cmd_reg.overlong <= q_cmd.overlong;
            out_last_reg <= (q_cmd.action != ACT_RELOAD);
        end
        else
        begin
            out_cmd_reg <= out_cmd_reg;
            out_last_reg <= out_last_reg;
        end
    end

endmodule

// ===== rtl/core/framed_gain_command_decoder.sv =====
// Top level of the framed gain command decoder: front end, command queue, result engine.
// Depends on fgcd_pkg, fgcd_front, fgcd_cmd_queue and fgcd_back.
//
// Usage:
//   s_* carries received bytes, one per transfer. Idle bytes other than the
//   start byte are dropped; inside a frame every byte but the end byte is
//   payload, and the end byte closes and decodes the frame.
//   m_* carries results: one per set-gain or no-op frame, three per reload
//   frame, with m_tlast on the final result of a frame.
//   cfg_* writes start_byte (index 0) and end_byte (index 1); write only
//   while idle. cfg_ready is always high.
// Path: on the end byte transfer the frame's command enters the command
//   queue, then is registered in the output register.
// Throughput: one byte per cycle while s_tready is high; the result engine
//   emits results one at a time, so a reload frame holds it for three results.
// Reset: start_byte 0xFF, end_byte 0xFE, idle, head bytes and gains zero.
// Stall: a held result stalls the result engine; the two-entry command queue
//   absorbs frame ends, and s_tready drops only while the queue is full.
module framed_gain_command_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [1:0] action, [2] motor, [4:3] gain_index,
                                    // [36:5] gain_bits, [37] overlong, [39:38] zero
    output logic        m_tlast,    // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import fgcd_pkg::*;

    logic byte_fire;
    logic cmd_push;
    cmd_t push_cmd;
    logic q_full;
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;
    cmd_t out_cmd;

    assign s_tready = !q_full;
    assign byte_fire = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    fgcd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_fire (byte_fire),
        .rx_byte   (s_tdata),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_push  (cmd_push),
        .cmd       (push_cmd)
    );

    fgcd_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    fgcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_cmd   (out_cmd),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, out_cmd.overlong, out_cmd.gain_bits, out_cmd.gain_index,
                      out_cmd.motor, out_cmd.action};

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_cmd.action == ACT_NOOP) || (out_cmd.action == ACT_SET)
                  || (out_cmd.action == ACT_RELOAD))
        else $error("undefined action code");

    a_reload_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_cmd.action == ACT_RELOAD)
            |-> (m_tlast == (out_cmd.gain_index == GIDX_KD)) && !out_cmd.motor)
        else $error("reload result misframed");

    a_noop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_cmd.action == ACT_NOOP)
            |-> m_tlast && (out_cmd.gain_bits == '0) && !out_cmd.motor)
        else $error("no-op result carries data");

endmodule
